/* hdl/prime_test_and_next_prime_assert.svh */
// Assertion macros shared by the prime test and next prime block.
`ifndef PRIME_TEST_AND_NEXT_PRIME_ASSERT_SVH
`define PRIME_TEST_AND_NEXT_PRIME_ASSERT_SVH

`ifndef SYNTHESIS
`define PTNP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prime block check failed");
`define PTNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prime block check failed");
`else
`define PTNP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTNP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/ptnp_pkg.sv */
// Shared constants and types of the prime test and next prime block.
package ptnp_pkg;

    localparam int WIDTH     = 32;
    localparam int OPER_W    = WIDTH - 1;
    localparam int SQ_W      = WIDTH + 1;
    localparam int MOD_CNT_W = $clog2(OPER_W);

    localparam int FIRST_DIV = 5;
    localparam int DIV_STEP  = 6;
    localparam int PRIME_TWO = 2;
    localparam int PRIME_THREE = 3;

    typedef struct packed {
        logic              start;
        logic [OPER_W-1:0] dividend;
        logic [OPER_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_rsp;

endpackage

/* hdl/ptnp_in_if.sv */
// Input channel: operation select and operand.
interface ptnp_in_if import ptnp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [WIDTH-1:0] number;

    modport source (output valid, output func, output number, input ready);
    modport sink   (input valid, input func, input number, output ready);
endinterface

/* hdl/ptnp_out_if.sv */
// Output channel: primality flag, next prime and overflow flag.
interface ptnp_out_if import ptnp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              prime_flag;
    logic [OPER_W-1:0] next_prime;
    logic              overflow;

    modport source (output valid, output prime_flag, output next_prime, output overflow,
                    input ready);
    modport sink   (input valid, input prime_flag, input next_prime, input overflow,
                    output ready);
endinterface

/* hdl/prime_test_and_next_prime.sv */
// Top level: trial division primality test and next prime search sequencer.
//
//   channel  | direction | beat contents
//   i_in     | sink      | func, number (signed)
//   o_out    | source    | prime_flag, next_prime, overflow
//
// One beat is taken at a time; i_in.ready is high only while the block is idle.
// Each candidate is checked by remainders taken by the shared bit-serial remainder unit:
// one remainder for 3, then two per pair 6k-1, 6k+1 while the divisor squared is at most
// the candidate. Next mode repeats this over every candidate up to the next prime.
// Reset is synchronous; no clearing pass is needed.
module prime_test_and_next_prime import ptnp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ptnp_in_if.sink    i_in,
    ptnp_out_if.source o_out
);

    `include "prime_test_and_next_prime_assert.svh"

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_MOD  = 5'b00100,
        S_LOOP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PH_THREE = 2'd0,
        PH_D     = 2'd1,
        PH_D2    = 2'd2
    } t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic              r_func, n_func;
    logic [OPER_W-1:0] r_n, n_n;
    logic [OPER_W-1:0] r_d, n_d;
    logic [SQ_W-1:0]   r_sq, n_sq;
    logic              r_flag, n_flag;
    logic [OPER_W-1:0] r_nxt, n_nxt;
    logic              r_ovf, n_ovf;

    t_mod_req mod_req;
    t_mod_rsp mod_rsp;
    logic     prime_hit;
    logic     comp_hit;
    logic     in_neg;
    logic     in_small;
    logic     in_max;

    ptnp_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign in_neg   = i_in.number[WIDTH-1];
    assign in_small = (i_in.number[WIDTH-2:1] == '0);
    assign in_max   = (i_in.number[WIDTH-2:0] == {OPER_W{1'b1}});

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_func   = r_func;
        n_n      = r_n;
        n_d      = r_d;
        n_sq     = r_sq;
        n_flag   = r_flag;
        n_nxt    = r_nxt;
        n_ovf    = r_ovf;
        prime_hit = 1'b0;
        comp_hit  = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = r_n;
        mod_req.divisor  = r_d;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func = i_in.func;
                    n_flag = 1'b0;
                    n_nxt  = '0;
                    n_ovf  = 1'b0;
                    if (in_neg || in_small) begin
                        n_flag  = i_in.func;
                        n_nxt   = i_in.func ? OPER_W'(PRIME_TWO) : '0;
                        n_state = S_DONE;
                    end else if (!i_in.func) begin
                        n_n     = i_in.number[WIDTH-2:0];
                        n_state = S_TEST;
                    end else if (in_max) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_n     = i_in.number[WIDTH-2:0] + 1'b1;
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                // The candidate is at least two here.
                if (r_n <= OPER_W'(PRIME_THREE)) begin
                    prime_hit = 1'b1;
                end else if (!r_n[0]) begin
                    comp_hit = 1'b1;
                end else begin
                    mod_req.start   = 1'b1;
                    mod_req.divisor = OPER_W'(PRIME_THREE);
                    n_phase = PH_THREE;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    if (mod_rsp.rem_zero) begin
                        comp_hit = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_THREE: begin
                                n_d     = OPER_W'(FIRST_DIV);
                                n_sq    = SQ_W'(FIRST_DIV * FIRST_DIV);
                                n_state = S_LOOP;
                            end
                            PH_D: begin
                                mod_req.start   = 1'b1;
                                mod_req.divisor = r_d + OPER_W'(2);
                                n_phase = PH_D2;
                            end
                            PH_D2: begin
                                // (d + 6)^2 = d^2 + 12d + 36, kept without a multiplier.
                                n_d     = r_d + OPER_W'(DIV_STEP);
                                n_sq    = r_sq + SQ_W'(2 * DIV_STEP) * SQ_W'(r_d)
                                        + SQ_W'(DIV_STEP * DIV_STEP);
                                n_state = S_LOOP;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_LOOP: begin
                if (r_sq <= SQ_W'(r_n)) begin
                    mod_req.start   = 1'b1;
                    mod_req.divisor = r_d;
                    n_phase = PH_D;
                    n_state = S_MOD;
                end else begin
                    prime_hit = 1'b1;
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (prime_hit) begin
            n_flag  = 1'b1;
            n_nxt   = r_func ? r_n : '0;
            n_ovf   = 1'b0;
            n_state = S_DONE;
        end else if (comp_hit) begin
            if (!r_func) begin
                n_flag  = 1'b0;
                n_nxt   = '0;
                n_ovf   = 1'b0;
                n_state = S_DONE;
            end else if (r_n == {OPER_W{1'b1}}) begin
                n_flag  = 1'b0;
                n_nxt   = '0;
                n_ovf   = 1'b1;
                n_state = S_DONE;
            end else begin
                n_n     = r_n + 1'b1;
                n_state = S_TEST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_phase <= n_phase;
        r_func  <= n_func;
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_flag  <= n_flag;
        r_nxt   <= n_nxt;
        r_ovf   <= n_ovf;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_DONE);
    assign o_out.prime_flag = r_flag;
    assign o_out.next_prime = r_nxt;
    assign o_out.overflow   = r_ovf;

    `PTNP_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `PTNP_ASSERT_NOW(a_ovf_clears, i_clk, i_rst_n, o_out.valid && o_out.overflow, !o_out.prime_flag && (o_out.next_prime == '0))
    `PTNP_ASSERT_NOW(a_mod_done_in_wait, i_clk, i_rst_n, mod_rsp.done, r_state == S_MOD)
    `PTNP_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)

endmodule

/* hdl/ptnp_mod_unit.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ptnp_mod_unit import ptnp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MOD_CNT_W-1:0] r_cnt, n_cnt;
    logic [OPER_W-1:0]    r_dvd, n_dvd;
    logic [OPER_W-1:0]    r_dsr, n_dsr;
    logic [OPER_W-1:0]    r_rem, n_rem;
    logic [OPER_W:0]      trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[OPER_W-1]};
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_dsr  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits after the subtract.
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = OPER_W'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = OPER_W'(trial);
            end
            n_dvd = {r_dvd[OPER_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == MOD_CNT_W'(OPER_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule
